FILE: hdl/abs_pkg.sv
`default_nettype none

package abs_pkg;

  localparam int MAX_GRID_POINTS_DEF = 4096;
  localparam int PTS_RESET_DEF       = 1024;

  // Q1.30 coordinate and power terms
  localparam int Q_W    = 31;
  localparam int Q_FRAC = 30;
  localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

  localparam int DIV_STAGES  = Q_W;
  localparam int SQ_STEPS    = 4;
  localparam int MERGE_REGS  = 2;
  localparam int PIPE_STAGES = 1 + DIV_STAGES + SQ_STEPS + MERGE_REGS;

  localparam int AMP_W = 32;
  localparam logic [AMP_W-1:0] AMP_ONE   = 32'd65536;
  localparam logic [AMP_W-1:0] AMP_RESET = 32'd6553600;

  // sum of up to three terms, and its integer part above Q_FRAC
  localparam int SUM_W = Q_W + 2;
  localparam int HI_W  = SUM_W - Q_FRAC;

  localparam int POT_W = 34;
  localparam logic [POT_W-1:0] POT_MAX = {POT_W{1'b1}};

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINTS_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_MODE = 3'd4;

  localparam int MODE_W = 6;
  localparam logic [MODE_W-1:0] MODE_XYZ      = 6'd3;
  localparam logic [MODE_W-1:0] MODE_XY       = 6'd2;
  localparam logic [MODE_W-1:0] MODE_XY_ALT   = 6'd6;
  localparam logic [MODE_W-1:0] MODE_X        = 6'd1;
  localparam logic [MODE_W-1:0] MODE_X_ALT_A  = 6'd5;
  localparam logic [MODE_W-1:0] MODE_X_ALT_B  = 6'd15;
  localparam logic [MODE_W-1:0] MODE_HALF     = 6'd4;
  localparam logic [MODE_W-1:0] MODE_HALF_A   = 6'd14;
  localparam logic [MODE_W-1:0] MODE_HALF_B   = 6'd24;
  localparam logic [MODE_W-1:0] MODE_HALF_C   = 6'd34;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_XYZ;

  typedef struct packed {
    logic valid;
    logic use_x;
    logic use_y;
    logic use_z;
    logic one_sided;
  } axis_sel_t;

  typedef struct packed {
    logic en;
    logic last_valid;
  } pipe_ctrl_t;

  function automatic axis_sel_t mode_decode(input logic [MODE_W-1:0] mode);
    axis_sel_t sel;
    sel = '0;
    case (mode)
      MODE_XYZ: begin
        sel.valid = 1'b1;
        sel.use_x = 1'b1;
        sel.use_y = 1'b1;
        sel.use_z = 1'b1;
      end
      MODE_XY, MODE_XY_ALT: begin
        sel.valid = 1'b1;
        sel.use_x = 1'b1;
        sel.use_y = 1'b1;
      end
      MODE_X, MODE_X_ALT_A, MODE_X_ALT_B: begin
        sel.valid = 1'b1;
        sel.use_x = 1'b1;
      end
      MODE_HALF, MODE_HALF_A, MODE_HALF_B, MODE_HALF_C: begin
        sel.valid     = 1'b1;
        sel.use_x     = 1'b1;
        sel.one_sided = 1'b1;
      end
      default: sel = '0;
    endcase
    return sel;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/abs_in_if.sv
`default_nettype none

interface abs_in_if #(
  parameter int IDX_W = $clog2(abs_pkg::MAX_GRID_POINTS_DEF)
);
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] x_index;
  logic [IDX_W-1:0] y_index;
  logic [IDX_W-1:0] z_index;

  modport source (output valid, output x_index, output y_index, output z_index, input ready);
  modport sink   (input valid, input x_index, input y_index, input z_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/abs_out_if.sv
`default_nettype none

interface abs_out_if;
  logic                        valid;
  logic                        ready;
  logic [abs_pkg::POT_W-1:0]   potential;

  modport source (output valid, output potential, input ready);
  modport sink   (input valid, input potential, output ready);
endinterface

`default_nettype wire

FILE: hdl/abs_lane.sv
`default_nettype none

// One axis: |u| in Q1.30 by a pipelined restoring divider, then u^16 by
// four saturating squarings.
module abs_lane #(
  parameter int IDX_W = $clog2(abs_pkg::MAX_GRID_POINTS_DEF),
  parameter int CNT_W = IDX_W + 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [IDX_W-1:0]          idx_i,
  input  wire logic [CNT_W-1:0]          count_i,
  input  wire logic                      one_sided_i,
  output logic      [abs_pkg::Q_W-1:0]   term_o
);

  localparam int V_W  = CNT_W + 1;
  localparam int NDIV = abs_pkg::DIV_STAGES;
  localparam int NSQ  = abs_pkg::SQ_STEPS;
  localparam int QW   = abs_pkg::Q_W;

  function automatic logic [QW-1:0] square_sat(input logic [QW-1:0] a);
    logic [2*QW-1:0] p;
    p = {{QW{1'b0}}, a} * {{QW{1'b0}}, a};
    if (p[2*QW-1]) begin
      return abs_pkg::Q_MAX;
    end
    return p[abs_pkg::Q_FRAC+QW-1:abs_pkg::Q_FRAC];
  endfunction

  logic [CNT_W-1:0] odd_idx;
  logic [CNT_W-1:0] span;
  logic [V_W-1:0]   numer;
  logic             sat_in;

  // numerator of u in units of 2^-29: 2|2i+1-N| centred, 2i+1 one-sided
  assign odd_idx = {idx_i, 1'b1};
  assign span    = (odd_idx >= count_i) ? (odd_idx - count_i) : (count_i - odd_idx);
  assign numer   = one_sided_i ? {1'b0, odd_idx} : {span, 1'b0};
  // quotient reaches 2^31 exactly when numer >= 4N
  assign sat_in  = ({1'b0, numer} >= {count_i, 2'b00});

  logic [CNT_W-1:0] rem_q  [NDIV];
  logic [1:0]       tail_q [NDIV];
  logic [QW-1:0]    quo_q  [NDIV+1];
  logic             sat_q  [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, numer[V_W-1:2]};
      tail_q[0] <= numer[1:0];
      quo_q[0]  <= '0;
      sat_q[0]  <= sat_in;
    end
  end

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    logic [CNT_W:0] shifted;
    logic [CNT_W:0] diff;
    logic           ge;

    assign shifted = {rem_q[s], tail_q[s][1]};
    assign ge      = (shifted >= {1'b0, count_i});
    assign diff    = shifted - {1'b0, count_i};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[s+1] <= {quo_q[s][QW-2:0], ge};
        sat_q[s+1] <= sat_q[s];
      end
    end

    if (s < NDIV - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s+1]  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
          tail_q[s+1] <= {tail_q[s][0], 1'b0};
        end
      end
    end
  end

  logic [QW-1:0] coord;
  logic [QW-1:0] sq_q [NSQ];

  assign coord = sat_q[NDIV] ? abs_pkg::Q_MAX : quo_q[NDIV];

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    if (k == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[k] <= square_sat(coord);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          sq_q[k] <= square_sat(sq_q[k-1]);
        end
      end
    end
  end

  assign term_o = sq_q[NSQ-1];

endmodule

`default_nettype wire

FILE: hdl/abs_merge.sv
`default_nettype none

// Sum the selected lane terms, scale by the amplitude, saturate, and hold
// the result in an output register backed by one skid entry.
module abs_merge (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire abs_pkg::pipe_ctrl_t           ctrl_i,
  input  wire abs_pkg::axis_sel_t            sel_i,
  input  wire logic [abs_pkg::AMP_W-1:0]     amplitude_i,
  input  wire logic [abs_pkg::Q_W-1:0]       term_x_i,
  input  wire logic [abs_pkg::Q_W-1:0]       term_y_i,
  input  wire logic [abs_pkg::Q_W-1:0]       term_z_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic      [abs_pkg::POT_W-1:0]     potential_o,
  output logic                               skid_free_o
);

  localparam int SUM_W = abs_pkg::SUM_W;
  localparam int HI_W  = abs_pkg::HI_W;
  localparam int FR    = abs_pkg::Q_FRAC;
  localparam int AW    = abs_pkg::AMP_W;
  localparam int LO_P  = FR + AW;
  localparam int HI_P  = HI_W + AW;
  localparam int RES_W = HI_P + 1;
  localparam int PW    = abs_pkg::POT_W;

  logic [SUM_W-1:0] tx, ty, tz, sum_d, sum_q;
  logic             gate;

  assign tx    = sel_i.use_x ? SUM_W'(term_x_i) : '0;
  assign ty    = sel_i.use_y ? SUM_W'(term_y_i) : '0;
  assign tz    = sel_i.use_z ? SUM_W'(term_z_i) : '0;
  assign gate  = sel_i.valid && (amplitude_i > abs_pkg::AMP_ONE);
  assign sum_d = gate ? (tx + ty + tz) : '0;

  logic [LO_P-1:0] plo_d, plo_q;
  logic [HI_P-1:0] phi_d, phi_q;

  // split the product at the binary point, as sum = hi + lo * 2^-30
  assign plo_d = LO_P'(sum_q[FR-1:0]) * LO_P'(amplitude_i);
  assign phi_d = HI_P'(sum_q[SUM_W-1:FR]) * HI_P'(amplitude_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      sum_q <= sum_d;
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  logic [RES_W-1:0] res_wide;
  logic [PW-1:0]    res;

  assign res_wide = RES_W'(phi_q) + RES_W'(plo_q[LO_P-1:FR]);
  assign res      = (res_wide > RES_W'(abs_pkg::POT_MAX)) ? abs_pkg::POT_MAX
                                                          : res_wide[PW-1:0];

  logic          o_v_q, s_v_q;
  logic [PW-1:0] o_data_q, s_data_q;
  logic          arrive, take;

  assign arrive = ctrl_i.en && ctrl_i.last_valid;
  assign take   = o_v_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else if (s_v_q) begin
      // drain skid into the output register
      if (take) begin
        s_v_q <= 1'b0;
      end
    end else if (arrive) begin
      if (o_v_q && !take) begin
        s_v_q <= 1'b1;
      end else begin
        o_v_q <= 1'b1;
      end
    end else if (take) begin
      o_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_v_q) begin
      if (take) begin
        o_data_q <= s_data_q;
      end
    end else if (arrive) begin
      if (o_v_q && !take) begin
        s_data_q <= res;
      end else begin
        o_data_q <= res;
      end
    end
  end

  assign out_valid_o = o_v_q;
  assign potential_o = o_data_q;
  assign skid_free_o = !s_v_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> o_v_q)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_v_q) |-> $past(o_v_q && !out_ready_i))
    else $error("skid entry filled although the output register could move");

  a_no_arrival_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> !arrive)
    else $error("pipeline delivered a result while the skid entry was full");

endmodule

`default_nettype wire

FILE: hdl/absorbing_potential_eval.sv
// Channel   Dir  Payload                          Transfer
// in_i      in   x_index, y_index, z_index        valid && ready
// out_o     out  potential (Q18.16, saturated)    valid && ready
// cfg       in   cfg_idx_i, cfg_data_i            cfg_we_i high at a clock edge
//
// Accepts one index triple per cycle while in_i.ready is high; each result
// passes through the input register, the 31-stage quotient pipeline in each
// axis lane, and the squaring and scaling registers before it is presented.
// Reset restores the register defaults; there is no memory to clear.
// A stalled output holds its result and one more in a skid entry; input
// ready drops only while that skid entry is full, and the pipe freezes.
`default_nettype none

module absorbing_potential_eval #(
  parameter int MAX_GRID_POINTS = abs_pkg::MAX_GRID_POINTS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  abs_in_if.sink                                 in_i,
  abs_out_if.source                              out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [abs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [abs_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int IDX_W   = $clog2(MAX_GRID_POINTS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int PTS_RST = (abs_pkg::PTS_RESET_DEF > MAX_GRID_POINTS)
                           ? MAX_GRID_POINTS : abs_pkg::PTS_RESET_DEF;
  localparam int NPIPE   = abs_pkg::PIPE_STAGES;

  logic [abs_pkg::AMP_W-1:0]  amplitude_q;
  logic [CNT_W-1:0]           points_x_q, points_y_q, points_z_q;
  logic [abs_pkg::MODE_W-1:0] grid_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amplitude_q <= abs_pkg::AMP_RESET;
      points_x_q  <= CNT_W'(PTS_RST);
      points_y_q  <= CNT_W'(PTS_RST);
      points_z_q  <= CNT_W'(PTS_RST);
      grid_mode_q <= abs_pkg::MODE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        abs_pkg::REG_AMPLITUDE: amplitude_q <= cfg_data_i[abs_pkg::AMP_W-1:0];
        abs_pkg::REG_POINTS_X:  points_x_q  <= cfg_data_i[CNT_W-1:0];
        abs_pkg::REG_POINTS_Y:  points_y_q  <= cfg_data_i[CNT_W-1:0];
        abs_pkg::REG_POINTS_Z:  points_z_q  <= cfg_data_i[CNT_W-1:0];
        abs_pkg::REG_GRID_MODE: grid_mode_q <= cfg_data_i[abs_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero point count acts as one
  logic [CNT_W-1:0] cnt_x, cnt_y, cnt_z;
  assign cnt_x = (points_x_q == '0) ? CNT_W'(1) : points_x_q;
  assign cnt_y = (points_y_q == '0) ? CNT_W'(1) : points_y_q;
  assign cnt_z = (points_z_q == '0) ? CNT_W'(1) : points_z_q;

  abs_pkg::axis_sel_t sel;
  assign sel = abs_pkg::mode_decode(grid_mode_q);

  logic             pipe_en;
  logic [NPIPE-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[NPIPE-2:0], in_i.valid};
    end
  end

  assign in_i.ready = pipe_en;

  logic [abs_pkg::Q_W-1:0] term_x, term_y, term_z;

  abs_lane #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_lane_x (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .idx_i       (in_i.x_index),
    .count_i     (cnt_x),
    .one_sided_i (sel.one_sided),
    .term_o      (term_x)
  );

  abs_lane #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_lane_y (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .idx_i       (in_i.y_index),
    .count_i     (cnt_y),
    .one_sided_i (1'b0),
    .term_o      (term_y)
  );

  abs_lane #(.IDX_W(IDX_W), .CNT_W(CNT_W)) u_lane_z (
    .clk_i       (clk_i),
    .en_i        (pipe_en),
    .idx_i       (in_i.z_index),
    .count_i     (cnt_z),
    .one_sided_i (1'b0),
    .term_o      (term_z)
  );

  abs_pkg::pipe_ctrl_t ctrl;
  assign ctrl.en         = pipe_en;
  assign ctrl.last_valid = vld_q[NPIPE-1];

  abs_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sel_i       (sel),
    .amplitude_i (amplitude_q),
    .term_x_i    (term_x),
    .term_y_i    (term_y),
    .term_z_i    (term_z),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .potential_o (out_o.potential),
    .skid_free_o (pipe_en)
  );

  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> out_o.valid)
    else $error("input stalled while no result waits at the output");

endmodule

`default_nettype wire

FILE: tb/tb_absorbing_potential_eval.sv
`default_nettype none

module tb_absorbing_potential_eval;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] z;
  } idx_triple_t;

  localparam logic [63:0] U_MAX     = 64'h7FFF_FFFF;
  localparam logic [63:0] FRAC_MASK = (64'd1 << abs_pkg::Q_FRAC) - 64'd1;
  localparam logic [abs_pkg::MODE_W-1:0] LISTED_MODES [10] = '{
    abs_pkg::MODE_XYZ, abs_pkg::MODE_XY, abs_pkg::MODE_XY_ALT, abs_pkg::MODE_X,
    abs_pkg::MODE_X_ALT_A, abs_pkg::MODE_X_ALT_B, abs_pkg::MODE_HALF,
    abs_pkg::MODE_HALF_A, abs_pkg::MODE_HALF_B, abs_pkg::MODE_HALF_C
  };
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASES       = 20;
  localparam int PHASE_ITEMS  = 22;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [abs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [abs_pkg::CFG_W-1:0]     cfg_data_i;

  abs_in_if  in_bus ();
  abs_out_if out_bus ();

  absorbing_potential_eval u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow of the register file
  logic [31:0]                amp_q;
  logic [12:0]                pts_x_q;
  logic [12:0]                pts_y_q;
  logic [12:0]                pts_z_q;
  logic [abs_pkg::MODE_W-1:0] mode_q;

  idx_triple_t               triple_pending [$];
  logic [abs_pkg::POT_W-1:0] pot_expected [$];
  idx_triple_t               drv_item;
  logic [abs_pkg::POT_W-1:0] pot_want;
  bit                        no_idle;
  int unsigned               in_gap;
  int unsigned               out_wait;
  int unsigned               stall_draw;
  int unsigned               n_errors = 0;

  // u^16 of one axis, Q1.30
  function automatic logic [63:0] axis_term(input logic [11:0] idx, input logic [12:0] n_raw,
                                            input bit one_sided);
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] m;
    logic [63:0] u;
    n = (n_raw == '0) ? 64'd1 : {51'd0, n_raw};
    a = {51'd0, idx, 1'b1};
    m = (a >= n) ? a - n : n - a;
    u = one_sided ? (a << (abs_pkg::Q_FRAC - 1)) / n : (m << abs_pkg::Q_FRAC) / n;
    if (u > U_MAX) u = U_MAX;
    for (int k = 0; k < abs_pkg::SQ_STEPS; k++) begin
      u = (u * u) >> abs_pkg::Q_FRAC;
      if (u > U_MAX) u = U_MAX;
    end
    return u;
  endfunction

  function automatic logic [abs_pkg::POT_W-1:0] calc_potential(input logic [11:0] xi,
                                                               input logic [11:0] yi,
                                                               input logic [11:0] zi);
    logic [63:0] sum;
    logic [63:0] res;
    bit          hit;
    sum = '0;
    res = '0;
    hit = 1'b1;
    case (mode_q)
      abs_pkg::MODE_XYZ: begin
        sum = axis_term(xi, pts_x_q, 1'b0) + axis_term(yi, pts_y_q, 1'b0)
            + axis_term(zi, pts_z_q, 1'b0);
      end
      abs_pkg::MODE_XY, abs_pkg::MODE_XY_ALT: begin
        sum = axis_term(xi, pts_x_q, 1'b0) + axis_term(yi, pts_y_q, 1'b0);
      end
      abs_pkg::MODE_X, abs_pkg::MODE_X_ALT_A, abs_pkg::MODE_X_ALT_B: begin
        sum = axis_term(xi, pts_x_q, 1'b0);
      end
      abs_pkg::MODE_HALF, abs_pkg::MODE_HALF_A, abs_pkg::MODE_HALF_B,
      abs_pkg::MODE_HALF_C: begin
        sum = axis_term(xi, pts_x_q, 1'b1);
      end
      default: hit = 1'b0;
    endcase
    if (hit && amp_q > abs_pkg::AMP_ONE) begin
      res = (sum >> abs_pkg::Q_FRAC) * amp_q
          + (((sum & FRAC_MASK) * amp_q) >> abs_pkg::Q_FRAC);
      if (res > abs_pkg::POT_MAX) res = abs_pkg::POT_MAX;
    end
    return res[abs_pkg::POT_W-1:0];
  endfunction

  function automatic idx_triple_t triple(input int unsigned x, input int unsigned y,
                                         input int unsigned z);
    return '{x[11:0], y[11:0], z[11:0]};
  endfunction

  function automatic logic [12:0] pick_points();
    case ($urandom_range(0, 9))
      0:       return 13'd0;
      1:       return 13'd1;
      2:       return 13'd2;
      3:       return 13'd4096;
      4, 5, 6: return 13'($urandom_range(1, 64));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  // mostly inside the grid, with edges and out-of-grid indices mixed in
  function automatic logic [11:0] pick_index(input logic [12:0] n_raw);
    int unsigned n;
    n = (n_raw == '0) ? 1 : ((n_raw > 13'd4096) ? 4096 : int'(n_raw));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 12'(n - 1);
      2, 3:    return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic flag_error(input string what);
    if (n_errors < 10) $display("mismatch: %s", what);
    n_errors++;
  endtask

  task automatic write_reg(input logic [abs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [abs_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      abs_pkg::REG_AMPLITUDE: amp_q   = data;
      abs_pkg::REG_POINTS_X:  pts_x_q = data[12:0];
      abs_pkg::REG_POINTS_Y:  pts_y_q = data[12:0];
      abs_pkg::REG_POINTS_Z:  pts_z_q = data[12:0];
      abs_pkg::REG_GRID_MODE: mode_q  = data[abs_pkg::MODE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] amp, input logic [12:0] nx, input logic [12:0] ny,
                            input logic [12:0] nz, input logic [abs_pkg::MODE_W-1:0] mode);
    write_reg(abs_pkg::REG_AMPLITUDE, amp);
    write_reg(abs_pkg::REG_POINTS_X, abs_pkg::CFG_W'(nx));
    write_reg(abs_pkg::REG_POINTS_Y, abs_pkg::CFG_W'(ny));
    write_reg(abs_pkg::REG_POINTS_Z, abs_pkg::CFG_W'(nz));
    write_reg(abs_pkg::REG_GRID_MODE, abs_pkg::CFG_W'(mode));
  endtask

  // hand a batch to the driver and hold until every result is back
  task automatic run_batch(input idx_triple_t batch [$], input bit quiet);
    @(negedge clk_i);
    no_idle = quiet;
    foreach (batch[i]) triple_pending.push_back(batch[i]);
    while (triple_pending.size() != 0 || in_bus.valid || pot_expected.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.x_index <= '0;
      in_bus.y_index <= '0;
      in_bus.z_index <= '0;
      in_gap         <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        pot_expected.push_back(calc_potential(in_bus.x_index, in_bus.y_index, in_bus.z_index));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (in_gap != 0) begin
          in_gap       <= in_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (triple_pending.size() != 0) begin
          drv_item = triple_pending.pop_front();
          in_bus.x_index <= drv_item.x;
          in_bus.y_index <= drv_item.y;
          in_bus.z_index <= drv_item.z;
          in_bus.valid   <= 1'b1;
          in_gap         <= no_idle ? 0 : $urandom_range(0, 3);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      out_wait      <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pot_expected.size() == 0) begin
          flag_error($sformatf("unexpected potential %0d", out_bus.potential));
        end else begin
          pot_want = pot_expected.pop_front();
          if (out_bus.potential !== pot_want)
            flag_error($sformatf("potential expected %0d got %0d", pot_want, out_bus.potential));
        end
        // draw the stall before the next transfer
        stall_draw = no_idle ? 0 : $urandom_range(0, 3);
        out_wait      <= stall_draw;
        out_bus.ready <= (stall_draw == 0);
      end else if (out_wait != 0) begin
        out_wait      <= out_wait - 1;
        out_bus.ready <= (out_wait == 1);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    idx_triple_t                batch [$];
    logic [31:0]                amp_v;
    logic [12:0]                nx_v;
    logic [12:0]                ny_v;
    logic [12:0]                nz_v;
    logic [abs_pkg::MODE_W-1:0] mode_v;

    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    no_idle        = 1'b0;
    amp_q          = abs_pkg::AMP_RESET;
    pts_x_q        = 13'(abs_pkg::PTS_RESET_DEF);
    pts_y_q        = 13'(abs_pkg::PTS_RESET_DEF);
    pts_z_q        = 13'(abs_pkg::PTS_RESET_DEF);
    mode_q         = abs_pkg::MODE_RESET;
    rst_ni         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // register defaults: corners, centre, alternating bit patterns
    batch.push_back(triple(0, 0, 0));
    batch.push_back(triple(4095, 4095, 4095));
    batch.push_back(triple(511, 512, 1023));
    batch.push_back(triple(1023, 0, 511));
    batch.push_back(triple(12'hAAA, 12'h555, 12'hAAA));
    batch.push_back(triple(12'h555, 12'hAAA, 12'h555));
    batch.push_back(triple(2048, 100, 4000));
    run_batch(batch, 1'b0);
    batch.delete();

    // full amplitude, tiny grids and a zero point count: saturation
    set_config(32'hFFFF_FFFF, 13'd1, 13'd4096, 13'd0, abs_pkg::MODE_XYZ);
    batch.push_back(triple(0, 0, 0));
    batch.push_back(triple(4095, 2048, 1));
    batch.push_back(triple(0, 2047, 4095));
    run_batch(batch, 1'b0);
    batch.delete();

    // amplitude right at and just above one
    set_config(abs_pkg::AMP_ONE, 13'd4096, 13'd4096, 13'd4096, abs_pkg::MODE_X);
    batch.push_back(triple(0, 0, 0));
    run_batch(batch, 1'b0);
    batch.delete();
    write_reg(abs_pkg::REG_AMPLITUDE, abs_pkg::AMP_ONE + 32'd1);
    batch.push_back(triple(0, 0, 0));
    batch.push_back(triple(4095, 0, 0));
    run_batch(batch, 1'b0);
    batch.delete();

    // one-sided coordinate
    set_config(abs_pkg::AMP_RESET, 13'd4096, 13'd1, 13'd1, abs_pkg::MODE_HALF);
    batch.push_back(triple(0, 7, 7));
    batch.push_back(triple(4095, 0, 0));
    batch.push_back(triple(2047, 4095, 4095));
    run_batch(batch, 1'b0);
    batch.delete();

    // unlisted codes at both ends
    write_reg(abs_pkg::REG_GRID_MODE, abs_pkg::CFG_W'(6'd0));
    batch.push_back(triple(0, 0, 0));
    run_batch(batch, 1'b0);
    batch.delete();
    write_reg(abs_pkg::REG_GRID_MODE, abs_pkg::CFG_W'(6'd63));
    batch.push_back(triple(4095, 4095, 4095));
    run_batch(batch, 1'b0);
    batch.delete();

    set_config(abs_pkg::AMP_RESET, 13'd2, 13'd3, 13'd4096, abs_pkg::MODE_XY);
    batch.push_back(triple(0, 1, 0));
    batch.push_back(triple(1, 2, 4095));
    run_batch(batch, 1'b0);
    batch.delete();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       amp_v = '0;
        1:       amp_v = abs_pkg::AMP_ONE;
        2:       amp_v = abs_pkg::AMP_ONE + 32'd1;
        3:       amp_v = '1;
        4:       amp_v = $urandom_range(65537, 1 << 24);
        default: amp_v = $urandom();
      endcase
      nx_v = pick_points();
      ny_v = pick_points();
      nz_v = pick_points();
      // walk every listed code first, then mix in arbitrary codes
      if (p < 10)
        mode_v = LISTED_MODES[p];
      else if ($urandom_range(0, 3) == 0)
        mode_v = abs_pkg::MODE_W'($urandom_range(0, 63));
      else
        mode_v = LISTED_MODES[$urandom_range(0, 9)];
      set_config(amp_v, nx_v, ny_v, nz_v, mode_v);
      for (int i = 0; i < PHASE_ITEMS; i++)
        batch.push_back(triple(pick_index(pts_x_q), pick_index(pts_y_q), pick_index(pts_z_q)));
      run_batch(batch, (p % 4) == 3);
      batch.delete();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && pot_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
